FILE: design/ors_pkg.sv
`default_nettype none

package ors_pkg;

    localparam int COORD_BITS = 16;
    localparam int SIZE_BITS  = COORD_BITS - 1;
    localparam int OUT_BITS   = COORD_BITS + 1;
    localparam int CALC_BITS  = COORD_BITS + 2;

    localparam int NUM_PIECES = 5;
    localparam int IDX_BITS   = 3;
    localparam logic [IDX_BITS-1:0] LAST_PIECE = IDX_BITS'(NUM_PIECES - 1);

    localparam int IN_FIELD_BITS = 4 * COORD_BITS + 4 * SIZE_BITS;
    localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = IDX_BITS + 4 * OUT_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [OUT_BITS-1:0] h;
        logic signed [OUT_BITS-1:0] w;
        logic signed [OUT_BITS-1:0] y;
        logic signed [OUT_BITS-1:0] x;
    } piece_t;

    typedef struct packed {
        logic                        hit;
        piece_t [NUM_PIECES-1:0]     piece;
    } split_t;

endpackage : ors_pkg

`default_nettype wire

FILE: design/overlap_rect_splitter.sv
// A request is written into a queue entry, and its first result is then loaded into the output register.
// An overlapping pair gives five results, a disjoint pair one result; the single output
// register, emitting one piece per cycle while the result side is ready, sets the rate.
// A two-entry queue of split results lets new requests be taken while pieces drain.
// Reset (rst_n, asynchronous, active low) empties the queue and clears the output valid.
`default_nettype none

module overlap_rect_splitter
    import ors_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    // Request channel.
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    // From bit 0 up: old_x, old_y, old_width, old_height,
    // new_x, new_y, new_width, new_height, zero padding.
    input  wire logic [IN_DATA_BITS-1:0]  s_axis_tdata,

    // Result channel.
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // From bit 0 up: piece_index, piece_x, piece_y, piece_width, piece_height, zero padding.
    output logic [OUT_DATA_BITS-1:0]      m_axis_tdata,
    // overlapped.
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast
);

    split_t split;
    split_t head_data;
    logic   full;
    logic   head_valid;
    logic   pop;
    logic   push;

    // The front end classifies the pair and works out all five pieces in one go.
    ors_front u_front
    (
        .tdata (s_axis_tdata),
        .split (split)
    );

    // A request is accepted whenever the queue has room, independent of the result side.
    assign s_axis_tready = !full;
    assign push          = s_axis_tvalid && !full;

    ors_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (split),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    // The back end walks through the pieces of the queue head and presents them
    // one by one; it releases the entry once the final result has been loaded.
    ors_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_data     (head_data),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule : overlap_rect_splitter

`default_nettype wire

FILE: design/ors_front.sv
`default_nettype none

module ors_front
    import ors_pkg::*;
(
    input  wire logic [IN_DATA_BITS-1:0] tdata,
    output split_t                       split
);

    logic signed [CALC_BITS-1:0] ox, oy, ow, oh, nx, ny, nw, nh;
    logic signed [CALC_BITS-1:0] n_right, o_right, n_bottom, o_bottom;
    logic signed [CALC_BITS-1:0] px [NUM_PIECES];
    logic signed [CALC_BITS-1:0] py [NUM_PIECES];
    logic signed [CALC_BITS-1:0] pw [NUM_PIECES];
    logic signed [CALC_BITS-1:0] ph [NUM_PIECES];
    logic hit_x, hit_y;

    localparam int OY_LO = COORD_BITS;
    localparam int OW_LO = 2 * COORD_BITS;
    localparam int OH_LO = OW_LO + SIZE_BITS;
    localparam int NX_LO = OH_LO + SIZE_BITS;
    localparam int NY_LO = NX_LO + COORD_BITS;
    localparam int NW_LO = NY_LO + COORD_BITS;
    localparam int NH_LO = NW_LO + SIZE_BITS;

    // Widen everything so that sums and differences cannot wrap.
    assign ox = {{(CALC_BITS-COORD_BITS){tdata[COORD_BITS-1]}}, tdata[COORD_BITS-1:0]};
    assign oy = {{(CALC_BITS-COORD_BITS){tdata[OY_LO+COORD_BITS-1]}},
                 tdata[OY_LO +: COORD_BITS]};
    assign ow = {{(CALC_BITS-SIZE_BITS){1'b0}}, tdata[OW_LO +: SIZE_BITS]};
    assign oh = {{(CALC_BITS-SIZE_BITS){1'b0}}, tdata[OH_LO +: SIZE_BITS]};
    assign nx = {{(CALC_BITS-COORD_BITS){tdata[NX_LO+COORD_BITS-1]}},
                 tdata[NX_LO +: COORD_BITS]};
    assign ny = {{(CALC_BITS-COORD_BITS){tdata[NY_LO+COORD_BITS-1]}},
                 tdata[NY_LO +: COORD_BITS]};
    assign nw = {{(CALC_BITS-SIZE_BITS){1'b0}}, tdata[NW_LO +: SIZE_BITS]};
    assign nh = {{(CALC_BITS-SIZE_BITS){1'b0}}, tdata[NH_LO +: SIZE_BITS]};

    assign n_right  = nx + nw;
    assign o_right  = ox + ow;
    assign n_bottom = ny + nh;
    assign o_bottom = oy + oh;

    always_comb
    begin
        for (int i = 0; i < NUM_PIECES; i++)
        begin
            px[i] = '0;
            py[i] = '0;
            pw[i] = '0;
            ph[i] = '0;
        end
        px[0] = nx;
        py[0] = ny;

        // Horizontal cut.
        if (nx < ox)
        begin
            hit_x = n_right > ox;
            pw[0] = ox - nx;
            px[1] = ox;
            if (n_right > o_right)
            begin
                pw[1] = ow;
                px[3] = o_right;
                pw[3] = n_right - o_right;
            end
            else
            begin
                pw[1] = n_right - ox;
            end
        end
        else
        begin
            hit_x = o_right > nx;
            px[1] = nx;
            if (n_right > o_right)
            begin
                pw[1] = o_right - nx;
                px[3] = o_right;
                pw[3] = n_right - o_right;
            end
            else
            begin
                pw[1] = nw;
            end
        end
        px[2] = px[1];
        px[4] = px[1];
        pw[2] = pw[1];
        pw[4] = pw[1];

        // Vertical cut; only meaningful when the horizontal test passed.
        ph[0] = nh;
        py[3] = ny;
        ph[3] = nh;
        py[4] = o_bottom;
        if (ny < oy)
        begin
            hit_y = n_bottom > oy;
            py[1] = ny;
            ph[1] = oy - ny;
            py[2] = oy;
            if (n_bottom > o_bottom)
            begin
                ph[2] = oh;
                ph[4] = n_bottom - o_bottom;
            end
            else
            begin
                ph[2] = n_bottom - oy;
            end
        end
        else
        begin
            hit_y = ny < o_bottom;
            py[2] = ny;
            if (n_bottom > o_bottom)
            begin
                ph[2] = o_bottom - ny;
                ph[4] = n_bottom - o_bottom;
            end
            else
            begin
                ph[2] = nh;
            end
        end
    end

    always_comb
    begin
        split.hit = hit_x & hit_y;
        for (int i = 0; i < NUM_PIECES; i++)
        begin
            split.piece[i].x = px[i][OUT_BITS-1:0];
            split.piece[i].y = py[i][OUT_BITS-1:0];
            split.piece[i].w = pw[i][OUT_BITS-1:0];
            split.piece[i].h = ph[i][OUT_BITS-1:0];
        end
    end

endmodule : ors_front

`default_nettype wire

FILE: design/ors_queue.sv
`default_nettype none

module ors_queue
    import ors_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire split_t push_data,
    output logic        full,
    input  wire logic   pop,
    output logic        head_valid,
    output split_t      head_data
);

    split_t                entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;

    assign full       = count_reg == CNT_BITS'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule : ors_queue

`default_nettype wire

FILE: design/ors_back.sv
`default_nettype none

module ors_back
    import ors_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     head_valid,
    input  wire split_t                   head_data,
    output logic                          pop,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0]      m_axis_tdata,
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast
);

    logic [IDX_BITS-1:0]       idx_reg, idx_next;
    logic                      valid_reg, valid_next;
    logic [OUT_DATA_BITS-1:0]  data_reg, data_next;
    logic                      user_reg, user_next;
    logic                      last_reg, last_next;
    logic                      load;
    piece_t                    sel;

    assign load = head_valid && (!valid_reg || m_axis_tready);

    always_comb
    begin
        unique case (idx_reg)
            3'd0:    sel = head_data.piece[0];
            3'd1:    sel = head_data.piece[1];
            3'd2:    sel = head_data.piece[2];
            3'd3:    sel = head_data.piece[3];
            3'd4:    sel = head_data.piece[4];
            default: sel = '0;
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
            user_next  = head_data.hit;
            last_next  = !head_data.hit || (idx_reg == LAST_PIECE);
            if (head_data.hit)
            begin
                data_next = OUT_DATA_BITS'({sel.h, sel.w, sel.y, sel.x, idx_reg});
            end
            else
            begin
                data_next = '0;
            end
            if (last_next)
            begin
                pop      = 1'b1;
                idx_next = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = user_reg;
    assign m_axis_tlast  = last_reg;

endmodule : ors_back

`default_nettype wire

FILE: sim/overlap_rect_splitter_tb.sv
`default_nettype none

// Self-checking bench for the dirty-rectangle splitter.
//
// Requests carry an existing rectangle and a new one. A predictor in this file
// cuts the new rectangle against the old one exactly as the block should. It
// yields either a single "no overlap" result or five pieces, numbered 0 to 4:
// left strip, top middle, overlap middle, right strip and bottom middle.
// Every result that leaves the block is checked, field by field, against the
// oldest outstanding prediction.
//
// The stimulus starts with a short list of hand-picked corner cases. These
// cover touching edges on all four sides, zero-sized rectangles on either side
// of the old left edge, rectangles that cover or sit inside the old one, and
// coordinates and sizes at the ends of their ranges. A random part follows.
// It is mostly pairs placed close together, so that every splitting branch is
// taken, mixed with pairs drawn over the full field ranges.

module overlap_rect_splitter_tb;
    import ors_pkg::*;

    // Watchdog: this many cycles without any handshake on either channel ends the run.
    localparam int IDLE_LIMIT     = 2000;
    localparam int RANDOM_PAIRS   = 190;
    // Once this many pieces have been checked, the result side holds off for a long stretch.
    localparam int HOLD_AFTER     = 40;
    localparam int HOLD_CYCLES    = 80;
    // Idling stops once fewer than this many requests are left to send.
    localparam int CALM_TAIL_LEFT = 30;
    localparam int MAX_REPORTS    = 40;
    localparam int DRAIN_CYCLES   = 8;

    // One request: the old rectangle and the new one, as they sit in tdata.
    typedef struct {
        logic signed [COORD_BITS-1:0] old_x;
        logic signed [COORD_BITS-1:0] old_y;
        logic        [SIZE_BITS-1:0]  old_width;
        logic        [SIZE_BITS-1:0]  old_height;
        logic signed [COORD_BITS-1:0] new_x;
        logic signed [COORD_BITS-1:0] new_y;
        logic        [SIZE_BITS-1:0]  new_width;
        logic        [SIZE_BITS-1:0]  new_height;
        // When set, the sender waits until every outstanding piece has come back.
        bit                           wait_for_drain;
    } rect_pair_t;

    // One result as it leaves the block.
    typedef struct {
        bit                         overlapped;
        logic [IDX_BITS-1:0]        idx;
        logic signed [OUT_BITS-1:0] x;
        logic signed [OUT_BITS-1:0] y;
        logic signed [OUT_BITS-1:0] w;
        logic signed [OUT_BITS-1:0] h;
        bit                         last;
    } piece_result_t;

    // All inputs of the block hold known values from time zero.
    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic                     m_axis_tuser;
    logic                     m_axis_tlast;

    rect_pair_t    queued_pairs[$];     // requests still to be sent
    piece_result_t pending_pieces[$];   // predicted results not yet seen

    int  mismatches      = 0;
    int  pairs_accepted  = 0;
    int  overlap_pairs   = 0;
    int  disjoint_pairs  = 0;
    int  pieces_checked  = 0;
    bit  calm_tail       = 1'b0;
    bit  long_hold_done  = 1'b0;

    overlap_rect_splitter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Cuts the new rectangle against the old one and queues the expected results.
    // Everything is worked out in plain integers, wide enough for every sum, and
    // truncated to the output width only when stored.
    function automatic void split_pair(input rect_pair_t r);
        int ox, oy, ow, oh, nx, ny, nw, nh;
        int px[NUM_PIECES];
        int py[NUM_PIECES];
        int pw[NUM_PIECES];
        int ph[NUM_PIECES];
        bit hit;
        piece_result_t res;

        ox = r.old_x;
        oy = r.old_y;
        ow = r.old_width;
        oh = r.old_height;
        nx = r.new_x;
        ny = r.new_y;
        nw = r.new_width;
        nh = r.new_height;
        hit = 1'b1;
        for (int i = 0; i < NUM_PIECES; i++)
        begin
            px[i] = 0;
            py[i] = 0;
            pw[i] = 0;
            ph[i] = 0;
        end
        px[0] = nx;
        py[0] = ny;

        // Horizontal cut. A new rectangle that starts left of the old one must
        // reach past the old left edge; one that starts at or right of it must
        // start before the old right edge, which a zero width may still do.
        if (nx < ox)
        begin
            if (nx + nw > ox)
            begin
                pw[0] = ox - nx;
                px[1] = ox;
                if (nx + nw > ox + ow)
                begin
                    pw[1] = ow;
                    px[3] = ox + ow;
                    pw[3] = nx + nw - px[3];
                end
                else
                    pw[1] = nx + nw - ox;
            end
            else
                hit = 1'b0;
        end
        else if (ox + ow > nx)
        begin
            px[1] = nx;
            if (nx + nw > ox + ow)
            begin
                pw[1] = ox + ow - nx;
                px[3] = ox + ow;
                pw[3] = nx + nw - px[3];
            end
            else
                pw[1] = nw;
        end
        else
            hit = 1'b0;

        // The three middle pieces share the middle column.
        px[2] = px[1];
        px[4] = px[1];
        pw[2] = pw[1];
        pw[4] = pw[1];

        // Vertical cut of the middle column into top, overlap and bottom.
        if (hit)
        begin
            ph[0] = nh;
            py[3] = ny;
            ph[3] = nh;
            py[4] = oy + oh;
            if (ny < oy)
            begin
                if (ny + nh > oy)
                begin
                    py[1] = ny;
                    ph[1] = oy - ny;
                    py[2] = oy;
                    if (ny + nh > oy + oh)
                    begin
                        ph[2] = oh;
                        ph[4] = ny + nh - py[4];
                    end
                    else
                        ph[2] = ny + nh - oy;
                end
                else
                    hit = 1'b0;
            end
            else if (ny < oy + oh)
            begin
                py[2] = ny;
                if (ny + nh > oy + oh)
                begin
                    ph[2] = oy + oh - ny;
                    ph[4] = ny + nh - py[4];
                end
                else
                    ph[2] = nh;
            end
            else
                hit = 1'b0;
        end

        if (!hit)
        begin
            // A disjoint pair gives a single all-zero result that closes the request.
            disjoint_pairs++;
            res = '{overlapped: 1'b0, idx: '0, x: '0, y: '0, w: '0, h: '0, last: 1'b1};
            pending_pieces.push_back(res);
        end
        else
        begin
            overlap_pairs++;
            for (int i = 0; i < NUM_PIECES; i++)
            begin
                res.overlapped = 1'b1;
                res.idx        = IDX_BITS'(i);
                res.x          = OUT_BITS'(px[i]);
                res.y          = OUT_BITS'(py[i]);
                res.w          = OUT_BITS'(pw[i]);
                res.h          = OUT_BITS'(ph[i]);
                res.last       = (res.idx == LAST_PIECE);
                pending_pieces.push_back(res);
            end
        end
    endfunction

    function automatic void add_pair(input int ox, input int oy, input int ow, input int oh,
                                     input int nx, input int ny, input int nw, input int nh,
                                     input bit drain);
        rect_pair_t p;

        p.old_x          = COORD_BITS'(ox);
        p.old_y          = COORD_BITS'(oy);
        p.old_width      = SIZE_BITS'(ow);
        p.old_height     = SIZE_BITS'(oh);
        p.new_x          = COORD_BITS'(nx);
        p.new_y          = COORD_BITS'(ny);
        p.new_width      = SIZE_BITS'(nw);
        p.new_height     = SIZE_BITS'(nh);
        p.wait_for_drain = drain;
        queued_pairs.push_back(p);
    endfunction

    // Mostly small sizes so that pieces of every kind appear, with zero, the
    // largest size and full-range values mixed in.
    function automatic int pick_size();
        int size;

        case ($urandom_range(0, 7))
            0:       size = 0;
            1:       size = $urandom_range(0, 32767);
            2:       size = 32767;
            default: size = $urandom_range(1, 64);
        endcase
        return size;
    endfunction

    // Request driver. A request, once offered, is held until it is taken. Between
    // requests the sender may idle for a short burst, and a request marked to wait
    // for the drain is held back until nothing is outstanding.
    always @(posedge clk or negedge rst_n)
    begin
        static rect_pair_t on_bus;
        static int         gap_left = 0;
        rect_pair_t        next_pair;

        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            gap_left      = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                split_pair(on_bus);
                pairs_accepted++;
            end

            if (s_axis_tvalid && !s_axis_tready)
            begin
                // The request stays on the bus unchanged.
            end
            else if (gap_left != 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (queued_pairs.size() == 0)
                s_axis_tvalid <= 1'b0;
            else if (queued_pairs[0].wait_for_drain
                     && (pending_pieces.size() != 0 || m_axis_tvalid))
                s_axis_tvalid <= 1'b0;
            else if (!calm_tail && $urandom_range(0, 99) < 15)
            begin
                gap_left = $urandom_range(0, 5);
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                next_pair = queued_pairs.pop_front();
                on_bus    = next_pair;
                s_axis_tdata <= {{(IN_DATA_BITS - IN_FIELD_BITS){1'b0}},
                                 next_pair.new_height, next_pair.new_width,
                                 next_pair.new_y, next_pair.new_x,
                                 next_pair.old_height, next_pair.old_width,
                                 next_pair.old_y, next_pair.old_x};
                s_axis_tvalid <= 1'b1;
            end

            calm_tail <= (queued_pairs.size() < CALM_TAIL_LEFT);
        end
    end

    // Result monitor and ready control. Each accepted result is compared with the
    // oldest prediction. The ready line stalls in short random bursts. Once, after
    // a few dozen pieces, it is held low for a long stretch, so that the block's
    // queue fills and it refuses further requests.
    always @(posedge clk or negedge rst_n)
    begin
        static int     stall_left = 0;
        static int     hold_left  = 0;
        piece_result_t got;
        piece_result_t want;

        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    = 0;
            hold_left     = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.overlapped = m_axis_tuser;
                got.idx        = m_axis_tdata[IDX_BITS-1:0];
                got.x          = $signed(m_axis_tdata[IDX_BITS +: OUT_BITS]);
                got.y          = $signed(m_axis_tdata[IDX_BITS + OUT_BITS +: OUT_BITS]);
                got.w          = $signed(m_axis_tdata[IDX_BITS + 2 * OUT_BITS +: OUT_BITS]);
                got.h          = $signed(m_axis_tdata[IDX_BITS + 3 * OUT_BITS +: OUT_BITS]);
                got.last       = m_axis_tlast;

                if (pending_pieces.size() == 0)
                    report_mismatch($sformatf("result with nothing outstanding (index %0d)",
                                              got.idx));
                else
                begin
                    want = pending_pieces.pop_front();
                    pieces_checked++;
                    if (got.overlapped !== want.overlapped)
                        report_mismatch($sformatf("overlapped got %0b want %0b",
                                                  got.overlapped, want.overlapped));
                    if (got.idx !== want.idx)
                        report_mismatch($sformatf("piece_index got %0d want %0d",
                                                  got.idx, want.idx));
                    if (got.x !== want.x)
                        report_mismatch($sformatf("piece %0d x got %0d want %0d",
                                                  want.idx, got.x, want.x));
                    if (got.y !== want.y)
                        report_mismatch($sformatf("piece %0d y got %0d want %0d",
                                                  want.idx, got.y, want.y));
                    if (got.w !== want.w)
                        report_mismatch($sformatf("piece %0d width got %0d want %0d",
                                                  want.idx, got.w, want.w));
                    if (got.h !== want.h)
                        report_mismatch($sformatf("piece %0d height got %0d want %0d",
                                                  want.idx, got.h, want.h));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("piece %0d last got %0b want %0b",
                                                  want.idx, got.last, want.last));
                end
            end

            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!long_hold_done && pieces_checked >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                hold_left      = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!calm_tail && $urandom_range(0, 99) < 12)
            begin
                stall_left = $urandom_range(0, 5);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: a long run of cycles in which neither channel moves means the block hung.
    always @(posedge clk)
    begin
        static int idle_cycles = 0;

        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timed out after %0d idle cycles, %0d pieces outstanding",
                         idle_cycles, pending_pieces.size());
                $display("overlap_rect_splitter verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int ox, oy, ow, oh, nx, ny, nw, nh;

        // Directed corner cases, old rectangle first, then the new one.
        add_pair(0, 0, 10, 10, 0, 0, 10, 10, 1'b0);            // identical
        add_pair(0, 0, 100, 100, 10, 20, 30, 40, 1'b0);        // new inside old
        add_pair(0, 0, 10, 10, -5, -5, 30, 30, 1'b0);          // new covers old, all pieces
        add_pair(100, 100, 50, 50, 40, 120, 60, 10, 1'b0);     // touches the left edge
        add_pair(100, 100, 50, 50, 150, 110, 20, 20, 1'b0);    // starts at the right edge
        add_pair(100, 100, 50, 50, 110, 60, 20, 40, 1'b0);     // touches the top edge
        add_pair(100, 100, 50, 50, 110, 150, 20, 20, 1'b0);    // starts at the bottom edge
        add_pair(100, 100, 50, 50, 90, 110, 0, 10, 1'b0);      // zero width, left of old
        add_pair(100, 100, 50, 50, 100, 100, 0, 0, 1'b0);      // zero size at old corner
        add_pair(100, 100, 50, 50, 80, 80, 40, 40, 1'b0);      // straddles top-left
        add_pair(100, 100, 50, 50, 130, 130, 40, 40, 1'b0);    // straddles bottom-right
        add_pair(100, 100, 50, 50, 120, 80, 10, 200, 1'b0);    // passes through vertically
        add_pair(100, 100, 0, 0, 100, 100, 10, 10, 1'b0);      // empty old rectangle
        add_pair(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767, 1'b0);
        add_pair(-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767, 1'b0);
        add_pair(-2, -2, 32767, 32767, -32768, -32768, 32767, 32767, 1'b0);
        add_pair(32767, 32767, 32767, 32767, -32768, -32768, 32767, 32767, 1'b0);
        add_pair(-20000, -20000, 300, 400, -32768, -32768, 32767, 32767, 1'b0);
        add_pair(0, 0, 32767, 32767, 16000, 16000, 32767, 32767, 1'b0);
        add_pair(32767, -32768, 1, 1, 32767, -32768, 1, 1, 1'b0);

        // Random pairs: most are placed near each other so that the pieces vary,
        // the rest are drawn over the whole range. Two of them make the sender
        // wait until everything outstanding has returned.
        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            ox = $urandom_range(0, 65535);
            oy = $urandom_range(0, 65535);
            ow = pick_size();
            oh = pick_size();
            nw = pick_size();
            nh = pick_size();
            if ($urandom_range(0, 9) < 3)
            begin
                nx = $urandom_range(0, 65535);
                ny = $urandom_range(0, 65535);
            end
            else
            begin
                nx = ox + $urandom_range(0, 160) - 80;
                ny = oy + $urandom_range(0, 160) - 80;
            end
            add_pair(ox, oy, ow, oh, nx, ny, nw, nh, (i == 100) || (i == 150));
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (queued_pairs.size() != 0 || s_axis_tvalid)
            @(negedge clk);
        while (pending_pieces.size() != 0)
            @(negedge clk);
        // Give the block time to show any result it should not produce.
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d rectangle pairs: %0d split into pieces, %0d disjoint; ",
                 pairs_accepted, overlap_pairs, disjoint_pairs,
                 "%0d results checked.", pieces_checked);
        $display("Covered edge-touching and zero-sized cases, range extremes, ",
                 "a long result stall and a drained pause.");
        if (mismatches == 0)
            $display("overlap_rect_splitter verification clean");
        else
            $display("overlap_rect_splitter verification failed");
        $finish;
    end

endmodule : overlap_rect_splitter_tb

`default_nettype wire
